FILE: src/wlm_pkg.sv
// Shared types and constants of the waypoint linear mover.
`default_nettype none
package wlm_pkg;
    localparam int POS_W   = 19;
    localparam int TICK_W  = 20;
    localparam int SPEED_W = 12;
    localparam int DELAY_W = 26;
    localparam int WAIT_W  = 27;
    localparam int CFG_W   = 26;
    localparam int IDX_W   = 3;
    localparam int D2_W    = 40;
    localparam int ROOT_W  = 20;
    localparam int DEN_W   = 40;
    localparam int Q_W     = 32;
    localparam int US_W    = 20;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    localparam logic [US_W-1:0]   US_PER_S = 20'd1000000;
    localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    localparam logic [IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_END_X   = 3'd2;
    localparam logic [IDX_W-1:0] REG_END_Y   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SPEED   = 3'd4;
    localparam logic [IDX_W-1:0] REG_DELAY   = 3'd5;

    typedef struct packed {
        logic capture;
        logic wait_upd;
        logic square;
        logic sum;
        logic snap;
        logic sqrt_init;
        logic sqrt_step;
        logic den;
        logic mul1;
        logic mul2;
        logic div_init;
        logic div_step;
        logic upd;
        logic axis;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_wait;
        logic near;
        logic flying;
    } t_status;
endpackage
`default_nettype wire

FILE: src/wlm_datapath.sv
// Datapath: position state, squares, root, products, divider and output word.
`default_nettype none
module wlm_datapath #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [wlm_pkg::IDX_W-1:0]  i_cfg_addr,
    input  wire logic [wlm_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic [wlm_pkg::TICK_W-1:0] i_tick,
    input  wire wlm_pkg::t_cmd              i_cmd,
    output wlm_pkg::t_status                o_status,
    output logic [wlm_pkg::POS_W-1:0]       o_pos_x,
    output logic [wlm_pkg::POS_W-1:0]       o_pos_y,
    output logic                            o_was_flying,
    output logic                            o_waiting,
    output logic                            o_arrived
);
    import wlm_pkg::*;

    localparam int P1_W  = POS_W + SPEED_W;
    localparam int NUM_W = P1_W + TICK_W + FRAC_BITS;
    localparam logic [D2_W-1:0] ONE_SQ = D2_W'(1) << (2 * FRAC_BITS);

    logic [POS_W-1:0]   r_end_x, r_end_y, r_cur_x, r_cur_y;
    logic [SPEED_W-1:0] r_speed;
    logic [DELAY_W-1:0] r_delay;
    logic [WAIT_W-1:0]  r_waited;
    logic               r_flying;
    logic [TICK_W-1:0]  r_tick;
    logic [POS_W-1:0]   r_ax, r_ay;
    logic               r_sx, r_sy, r_was, r_wait;
    logic [2*POS_W-1:0] r_sqx, r_sqy;
    logic [D2_W-1:0]    r_d2, r_rad;
    logic [ROOT_W:0]    r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [DEN_W-1:0]   r_den, r_drem;
    logic [P1_W-1:0]    r_p1;
    logic [NUM_W-1:0]   r_num;
    logic [Q_W-1:0]     r_nsh, r_q;

    logic [POS_W:0]     dx, dy;
    logic [WAIT_W:0]    wsum;
    logic [ROOT_W+2:0]  rs;
    logic [ROOT_W+3:0]  trial;
    logic [DEN_W:0]     drs;
    logic [POS_W-1:0]   mag, pos;
    logic               sgn;
    logic [Q_W:0]       psum;
    logic [POS_W-1:0]   n_pos;

    always_comb begin
        dx    = {1'b0, r_end_x} - {1'b0, r_cur_x};
        dy    = {1'b0, r_end_y} - {1'b0, r_cur_y};
        wsum  = {1'b0, r_waited} + (WAIT_W + 1)'(r_tick);
        rs    = {r_rem, r_rad[D2_W-1 -: 2]};
        trial = {1'b0, rs} - {2'b00, r_root, 2'b01};
        drs   = {r_drem, r_nsh[Q_W-1]};
        mag   = i_cmd.axis ? r_ay : r_ax;
        sgn   = i_cmd.axis ? r_sy : r_sx;
        pos   = i_cmd.axis ? r_cur_y : r_cur_x;
        psum  = (Q_W + 1)'(pos) + {1'b0, r_q};
        if (sgn) begin
            n_pos = (r_q > Q_W'(pos)) ? '0 : POS_W'(Q_W'(pos) - r_q);
        end else begin
            n_pos = (psum > (Q_W + 1)'(POS_MAX)) ? POS_MAX : psum[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_x  <= '0;
            r_end_y  <= '0;
            r_speed  <= '0;
            r_delay  <= '0;
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_waited <= '0;
            r_flying <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_START_X: begin
                        r_cur_x  <= i_cfg_data[POS_W-1:0];
                        r_waited <= '0;
                        r_flying <= 1'b1;
                    end
                    REG_START_Y: begin
                        r_cur_y  <= i_cfg_data[POS_W-1:0];
                        r_waited <= '0;
                        r_flying <= 1'b1;
                    end
                    REG_END_X: r_end_x <= i_cfg_data[POS_W-1:0];
                    REG_END_Y: r_end_y <= i_cfg_data[POS_W-1:0];
                    REG_SPEED: r_speed <= i_cfg_data[SPEED_W-1:0];
                    REG_DELAY: r_delay <= i_cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.wait_upd) begin
                r_waited <= wsum[WAIT_W] ? WAIT_MAX : wsum[WAIT_W-1:0];
            end
            if (i_cmd.snap) begin
                r_cur_x  <= r_end_x;
                r_cur_y  <= r_end_y;
                r_flying <= 1'b0;
            end
            if (i_cmd.upd) begin
                if (i_cmd.axis) begin
                    r_cur_y <= n_pos;
                end else begin
                    r_cur_x <= n_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tick <= i_tick;
            r_was  <= r_flying;
            r_wait <= 1'b0;
            r_sx   <= dx[POS_W];
            r_sy   <= dy[POS_W];
            r_ax   <= dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
            r_ay   <= dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
        end
        if (i_cmd.wait_upd) begin
            r_wait <= 1'b1;
        end
        if (i_cmd.square) begin
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
        end
        if (i_cmd.sum) begin
            r_d2 <= D2_W'(r_sqx) + D2_W'(r_sqy);
        end
        if (i_cmd.sqrt_init) begin
            r_rad  <= r_d2;
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rad <= r_rad << 2;
            if (!trial[ROOT_W+3]) begin
                r_rem  <= trial[ROOT_W:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rs[ROOT_W:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.den) begin
            r_den <= r_root * US_PER_S;
        end
        if (i_cmd.mul1) begin
            r_p1 <= mag * r_speed;
        end
        if (i_cmd.mul2) begin
            r_num <= (NUM_W'(r_p1) * NUM_W'(r_tick)) << FRAC_BITS;
        end
        if (i_cmd.div_init) begin
            r_drem <= DEN_W'(r_num >> Q_W);
            r_nsh  <= r_num[Q_W-1:0];
            r_q    <= '0;
        end
        if (i_cmd.div_step) begin
            r_nsh <= r_nsh << 1;
            if (drs >= {1'b0, r_den}) begin
                r_drem <= DEN_W'(drs - {1'b0, r_den});
                r_q    <= {r_q[Q_W-2:0], 1'b1};
            end else begin
                r_drem <= drs[DEN_W-1:0];
                r_q    <= {r_q[Q_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            o_pos_x      <= r_cur_x;
            o_pos_y      <= r_cur_y;
            o_was_flying <= r_was;
            o_waiting    <= r_wait;
            o_arrived    <= !r_flying;
        end
    end

    assign o_status.is_wait = r_waited < WAIT_W'(r_delay);
    assign o_status.near    = r_d2 <= ONE_SQ;
    assign o_status.flying  = r_flying;
endmodule
`default_nettype wire

FILE: src/wlm_ctrl.sv
// Controller: sequences one tick through the datapath and owns the output handshake.
`default_nettype none
module wlm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire wlm_pkg::t_status i_status,
    output wlm_pkg::t_cmd         o_cmd
);
    import wlm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_SUM  = 4'd2;
    localparam logic [3:0] S_TEST = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_DEN  = 4'd5;
    localparam logic [3:0] S_MUL1 = 4'd6;
    localparam logic [3:0] S_MUL2 = 4'd7;
    localparam logic [3:0] S_DIVI = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_UPD  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(Q_W - 1);

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_axis, n_axis;
    logic             r_out_valid, n_out_valid;
    logic             accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_status.is_wait) begin
                    o_cmd.wait_upd = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.square = 1'b1;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_TEST;
            end
            S_TEST: begin
                if (i_status.near) begin
                    o_cmd.snap = 1'b1;
                    n_state = S_DONE;
                end else if (!i_status.flying) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.sqrt_init = 1'b1;
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                o_cmd.den = 1'b1;
                n_axis  = 1'b0;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (r_axis) begin
                    n_state = S_DONE;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_MUL1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten while stalled");
    a_accept_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CHK))
        else $error("accepted word not checked");
    a_sqrt_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_cnt <= SQRT_LAST))
        else $error("root counter overrun");
    a_upd_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.upd && !r_axis) |=> (r_state == S_MUL1 && r_axis))
        else $error("second axis skipped");
endmodule
`default_nettype wire

FILE: src/waypoint_linear_mover.sv
// Top level of the waypoint linear mover.
// Each input word carries one tick in microseconds and yields one output word.
// A tick spent in the start delay only adds to the wait; a snap or a stalled point
// stops after the distance test; a moving step runs the 20-step square root once
// and the 32-step divider once per axis. The next word is taken once the
// previous result is in the output register. Write registers only while idle.
`default_nettype none
module waypoint_linear_mover #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [wlm_pkg::IDX_W-1:0]       i_cfg_addr,
    input  wire logic [wlm_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tick_us[19:0], zeros above
    input  wire logic [wlm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // pos_x[18:0], pos_y[37:19], was_flying[38], waiting[39], arrived[40], zeros above
    output logic [wlm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import wlm_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic [POS_W-1:0] pos_x, pos_y;
    logic             was_flying, waiting, arrived;

    wlm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wlm_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_tick       (s_axis_tdata[TICK_W-1:0]),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_pos_x      (pos_x),
        .o_pos_y      (pos_y),
        .o_was_flying (was_flying),
        .o_waiting    (waiting),
        .o_arrived    (arrived)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - 2 * POS_W - 3)'(0),
                           arrived, waiting, was_flying, pos_y, pos_x};
endmodule
`default_nettype wire

FILE: verif/tb_waypoint_linear_mover.sv
// Testbench for the waypoint linear mover: directed and random ticks checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_waypoint_linear_mover;
    import wlm_pkg::*;

    localparam int FRAC = 8;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             was_flying;
        logic             waiting;
        logic             arrived;
    } t_step;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [IDX_W-1:0]       i_cfg_addr = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    waypoint_linear_mover #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // mover state mirrored here
    logic [POS_W-1:0]   m_end_x, m_end_y, m_cur_x, m_cur_y;
    logic [SPEED_W-1:0] m_speed;
    logic [DELAY_W-1:0] m_delay;
    logic [WAIT_W-1:0]  m_waited;
    logic               m_flying;

    t_step expected_steps[$];
    int    n_errors = 0;
    int    idle_cycles = 0;
    int    ready_gap = 0;
    bit    calm = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [POS_W-1:0] axis_move(input logic [POS_W-1:0] pos,
            input longint d, input logic [63:0] len, input logic [TICK_W-1:0] tick);
        logic [63:0] mag, num, stp;
        longint np;
        mag = (d < 0) ? -d : d;
        num = mag * m_speed * tick * (64'd1 << FRAC);
        stp = num / (len * 64'd1000000);
        np = (d < 0) ? longint'(pos) - longint'(stp) : longint'(pos) + longint'(stp);
        if (np < 0) return '0;
        if (np > longint'(POS_MAX)) return POS_MAX;
        return np[POS_W-1:0];
    endfunction

    function automatic t_step predict_step(input logic [TICK_W-1:0] tick);
        t_step r;
        longint dx, dy;
        logic [63:0] d2, w, len;
        r.was_flying = m_flying;
        r.waiting = 1'b0;
        if (m_waited < m_delay) begin
            w = m_waited + tick;
            m_waited = (w > WAIT_MAX) ? WAIT_MAX : w[WAIT_W-1:0];
            r.waiting = 1'b1;
        end else begin
            dx = longint'(m_end_x) - longint'(m_cur_x);
            dy = longint'(m_end_y) - longint'(m_cur_y);
            d2 = dx * dx + dy * dy;
            if (d2 <= (64'd1 << (2 * FRAC))) begin
                m_cur_x = m_end_x;
                m_cur_y = m_end_y;
                m_flying = 1'b0;
            end else if (m_flying) begin
                len = root_floor(d2);
                m_cur_x = axis_move(m_cur_x, dx, len, tick);
                m_cur_y = axis_move(m_cur_y, dy, len, tick);
            end
        end
        r.pos_x = m_cur_x;
        r.pos_y = m_cur_y;
        r.arrived = ~m_flying;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
            input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_START_X: begin
                m_cur_x = val[POS_W-1:0]; m_waited = '0; m_flying = 1'b1;
            end
            REG_START_Y: begin
                m_cur_y = val[POS_W-1:0]; m_waited = '0; m_flying = 1'b1;
            end
            REG_END_X: m_end_x = val[POS_W-1:0];
            REG_END_Y: m_end_y = val[POS_W-1:0];
            REG_SPEED: m_speed = val[SPEED_W-1:0];
            REG_DELAY: m_delay = val[DELAY_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_tick(input logic [TICK_W-1:0] tick);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_W-TICK_W){1'b0}}, tick};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_steps.push_back(predict_step(tick));
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic load_flight(input logic [POS_W-1:0] sx, sy, ex, ey,
            input logic [SPEED_W-1:0] spd, input logic [DELAY_W-1:0] dly);
        write_reg(REG_END_X, CFG_W'(ex));
        write_reg(REG_END_Y, CFG_W'(ey));
        write_reg(REG_SPEED, CFG_W'(spd));
        write_reg(REG_DELAY, dly);
        write_reg(REG_START_X, CFG_W'(sx));
        write_reg(REG_START_Y, CFG_W'(sy));
    endtask

    task automatic test_reset_state;
        send_tick('0);
        send_tick(20'hFFFFF);
        drain();
    endtask

    task automatic test_directed;
        // wait, then fly out of range both ways
        load_flight(19'd0, 19'd0, POS_MAX, POS_MAX, 12'hFFF, 26'h3FFFFFF);
        send_tick(20'hFFFFF);
        repeat (3) send_tick(20'hFFFFF);
        drain();
        load_flight(19'd1000, 19'd1000, POS_MAX, 19'd0, 12'hFFF, '0);
        send_tick(20'hFFFFF);
        send_tick('0);
        send_tick(20'hFFFFF);
        drain();
        load_flight(POS_MAX, POS_MAX, 19'd0, 19'd0, 12'hFFF, '0);
        send_tick(20'hFFFFF);
        send_tick(20'hFFFFF);
        drain();
        // zero speed, then snap exactly at one pixel
        load_flight(19'd5000, 19'd5000, 19'd6000, 19'd6000, '0, '0);
        send_tick(20'd50000);
        drain();
        load_flight(19'd5000, 19'd5000, 19'd5256, 19'd5000, 12'd10, 26'd1);
        send_tick(20'd1);
        send_tick(20'd1);
        send_tick(20'd1);
        drain();
        // end moved after arrival: far stays put, near snaps again
        write_reg(REG_END_X, 26'd90000);
        send_tick(20'd1000);
        drain();
        write_reg(REG_END_X, 26'd5100);
        write_reg(3'd7, 26'h2AAAA);
        send_tick(20'd1000);
        drain();
    endtask

    task automatic test_random_flights;
        int n;
        n = 0;
        while (n < 950) begin
            if ($urandom_range(0, 2) == 0)
                load_flight(POS_W'($urandom_range(0, 524287)),
                    POS_W'($urandom_range(0, 524287)),
                    POS_W'($urandom_range(0, 524287)),
                    POS_W'($urandom_range(0, 524287)),
                    SPEED_W'($urandom_range(0, 4095)),
                    DELAY_W'($urandom_range(0, 67108863)));
            else
                load_flight(POS_W'($urandom_range(0, 40000)),
                    POS_W'($urandom_range(0, 40000)),
                    POS_W'($urandom_range(0, 40000)),
                    POS_W'($urandom_range(0, 40000)),
                    SPEED_W'($urandom_range(1, 4095)),
                    DELAY_W'($urandom_range(0, 50000)));
            if (n > 800) calm = 1'b1;
            repeat ($urandom_range(5, 30)) begin
                case ($urandom_range(0, 3))
                    0: send_tick(TICK_W'($urandom));
                    1: send_tick(TICK_W'($urandom_range(0, 100)));
                    default: send_tick(TICK_W'($urandom_range(1000, 40000)));
                endcase
                n++;
            end
            drain();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            m_axis_tready <= 1'b1;
            ready_gap <= 0;
        end else if (ready_gap > 0) begin
            m_axis_tready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            ready_gap <= $urandom_range(0, 9);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_step got, want;
        if (m_axis_tvalid && m_axis_tready && i_rst_n) begin
            got = {m_axis_tdata[18:0], m_axis_tdata[37:19], m_axis_tdata[38],
                   m_axis_tdata[39], m_axis_tdata[40]};
            if (expected_steps.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata[31:0], '0);
            end else begin
                want = expected_steps.pop_front();
                if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
                if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
                if (got.was_flying !== want.was_flying)
                    report_mismatch("was_flying", got.was_flying, want.was_flying);
                if (got.waiting !== want.waiting)
                    report_mismatch("waiting", got.waiting, want.waiting);
                if (got.arrived !== want.arrived)
                    report_mismatch("arrived", got.arrived, want.arrived);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        m_end_x = '0; m_end_y = '0; m_cur_x = '0; m_cur_y = '0;
        m_speed = '0; m_delay = '0; m_waited = '0; m_flying = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_directed();
        test_random_flights();
        if (n_errors == 0 && expected_steps.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
